// ===== src/fcpa_pkg.sv =====
// shared types, constants and codes of the fixed chunk pool allocator
package fcpa_pkg;

  localparam int MAX_CHUNKS = 1024;
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int ADDR_W     = 48;
  localparam int BYTES_W    = 21;
  localparam int PROD_W     = IDX_W + BYTES_W;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int LINK_W     = IDX_W + 1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OOM   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT = 2'd2;

  localparam logic [ADDR_W-1:0]  POOL_BASE_RST   = '0;
  localparam logic [BYTES_W-1:0] CHUNK_BYTES_RST = 21'd4096;
  localparam logic [CNT_W-1:0]   CHUNK_COUNT_RST = 11'd1024;

  typedef struct packed {
    logic             req_type;
    logic [IDX_W-1:0] chunk_index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    granted_index;
    logic [ADDR_W-1:0]   granted_address;
    logic                from_free_list;
  } rsp_t;

  typedef struct packed {
    logic accept;
    logic calc;
    logic finish;
  } cmd_t;

endpackage

// ===== src/fcpa_ram.sv =====
// generic single-port ram with registered read
module fcpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/fcpa_ctrl.sv =====
// request sequencing state machine and output handshake of the allocator
module fcpa_ctrl
  import fcpa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CALC   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_CALC;
      end
      ST_CALC: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o.accept = accept;
  assign cmd_o.calc   = (state_q == ST_CALC);
  assign cmd_o.finish = (state_q == ST_FINISH);
  assign out_valid_o  = out_valid_q;

  a_valid_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result valid without a finished request");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_CALC) ##1 (state_q == ST_FINISH))
    else $error("request sequence broken");

endmodule

// ===== src/fcpa_dp.sv =====
// free list, bump counter, configuration and address datapath of the allocator
module fcpa_dp
  import fcpa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  input  req_t                 in_req_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_W-1:0]    cfg_wdata_i,
  output rsp_t                 out_rsp_o
);

  logic [ADDR_W-1:0]   pool_base_q;
  logic [BYTES_W-1:0]  chunk_bytes_q;
  logic [CNT_W-1:0]    chunk_count_q;
  logic [CNT_W-1:0]    limit;

  logic [IDX_W-1:0]    head_q, head_d;
  logic                nonempty_q, nonempty_d;
  logic [CNT_W-1:0]    bump_q, bump_d;

  logic [IDX_W-1:0]    gidx_q, gidx_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                recyc_q, recyc_d;
  logic                grant_q, grant_d;
  logic [PROD_W-1:0]   prod_q;
  rsp_t                rsp_q;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_addr;
  logic [LINK_W-1:0]   ram_wdata;
  logic [LINK_W-1:0]   ram_rdata;
  logic                rel_ok;

  assign limit  = (chunk_count_q > CNT_W'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS) : chunk_count_q;
  assign rel_ok = {1'b0, in_req_i.chunk_index} < limit;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q   <= POOL_BASE_RST;
      chunk_bytes_q <= CHUNK_BYTES_RST;
      chunk_count_q <= CHUNK_COUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POOL_BASE:   pool_base_q   <= cfg_wdata_i;
        CFG_CHUNK_BYTES: chunk_bytes_q <= cfg_wdata_i[BYTES_W-1:0];
        CFG_CHUNK_COUNT: chunk_count_q <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // link table entry: end mark over next link
  assign ram_we    = cmd_i.accept && (in_req_i.req_type == REQ_RELEASE) && rel_ok;
  assign ram_addr  = ram_we ? in_req_i.chunk_index : head_q;
  assign ram_wdata = {!nonempty_q, head_q};

  fcpa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (MAX_CHUNKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    head_d     = head_q;
    nonempty_d = nonempty_q;
    bump_d     = bump_q;
    gidx_d     = gidx_q;
    status_d   = status_q;
    recyc_d    = recyc_q;
    grant_d    = grant_q;
    if (cmd_i.accept) begin
      gidx_d   = '0;
      status_d = STATUS_OK;
      recyc_d  = 1'b0;
      grant_d  = 1'b0;
      if (in_req_i.req_type == REQ_ALLOC) begin
        if (nonempty_q) begin
          gidx_d  = head_q;
          recyc_d = 1'b1;
          grant_d = 1'b1;
        end else if (bump_q < limit) begin
          gidx_d  = bump_q[IDX_W-1:0];
          grant_d = 1'b1;
          bump_d  = bump_q + 1'b1;
        end else begin
          status_d = STATUS_OOM;
        end
      end else if (rel_ok) begin
        head_d     = in_req_i.chunk_index;
        nonempty_d = 1'b1;
      end else begin
        status_d = STATUS_RANGE;
      end
    end
    // pop: follow the link read at accept time
    if (cmd_i.calc && recyc_q) begin
      if (ram_rdata[IDX_W]) begin
        nonempty_d = 1'b0;
        head_d     = '0;
      end else begin
        head_d = ram_rdata[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      nonempty_q <= 1'b0;
      bump_q     <= '0;
    end else begin
      head_q     <= head_d;
      nonempty_q <= nonempty_d;
      bump_q     <= bump_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gidx_q   <= gidx_d;
    status_q <= status_d;
    recyc_q  <= recyc_d;
    grant_q  <= grant_d;
    if (cmd_i.calc) begin
      prod_q <= PROD_W'(gidx_q) * PROD_W'(chunk_bytes_q);
    end
    if (cmd_i.finish) begin
      rsp_q.status          <= status_q;
      rsp_q.granted_index   <= gidx_q;
      rsp_q.granted_address <= grant_q ? (pool_base_q + ADDR_W'(prod_q)) : '0;
      rsp_q.from_free_list  <= recyc_q;
    end
  end

  assign out_rsp_o = rsp_q;

  a_bump_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bump_q <= CNT_W'(MAX_CHUNKS))
    else $error("bump counter beyond pool size");

  a_bump_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bump_q != $past(bump_q)) |-> (bump_q == $past(bump_q) + 1'b1))
    else $error("bump counter moved by more than one");

  a_release_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> nonempty_q && (head_q == $past(in_req_i.chunk_index)))
    else $error("released chunk not at free list head");

endmodule

// ===== src/fixed_chunk_pool_allocator.sv =====
// top level of the fixed chunk pool allocator
//
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_ready_o    in_req_i (req_t)
// out       output     out_valid_o / out_ready_i  out_rsp_o (rsp_t)
// cfg       input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// each request steps through accept with link table read, multiply and
// link follow, address add into the output register
// a new request is taken once the sequencer is back idle and the output
// register is empty or being drained, so one request is in flight at a time
// reset clears the free list and bump counter, no clearing pass
// a stalled result holds in the output register and blocks further requests
module fixed_chunk_pool_allocator
  import fcpa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  req_t                 in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rsp_t                 out_rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_W-1:0]    cfg_wdata_i
);

  cmd_t cmd;

  fcpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  fcpa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// ===== bench/fcpa_checker.sv =====
// checker for the chunk pool allocator: watches all three channels, predicts grants and compares
`timescale 1ns / 100ps

module fcpa_checker
  import fcpa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  req_t                 in_req_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  rsp_t                 out_rsp_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ADDR_W-1:0]    cfg_wdata_i,
  output int                   pending_o,
  output int                   fail_count_o
);

  logic [ADDR_W-1:0]  base_reg;
  logic [BYTES_W-1:0] bytes_reg;
  logic [CNT_W-1:0]   count_reg;

  logic [IDX_W-1:0] link_next [MAX_CHUNKS];
  logic             link_last [MAX_CHUNKS];
  logic [IDX_W-1:0] head;
  logic             list_nonempty;
  logic [CNT_W-1:0] bump;

  rsp_t due_grants [$];
  int   fails = 0;

  assign fail_count_o = fails;

  task automatic report(string msg);
    fails++;
    if (fails <= 50) $display("%0t: %s", $time, msg);
  endtask

  function automatic logic [ADDR_W-1:0] chunk_address(logic [IDX_W-1:0] idx);
    return base_reg + ADDR_W'(idx) * ADDR_W'(bytes_reg);
  endfunction

  function automatic rsp_t pool_serve(req_t r);
    rsp_t             g;
    logic [CNT_W-1:0] lim;
    g   = '0;
    lim = (count_reg > MAX_CHUNKS) ? CNT_W'(MAX_CHUNKS) : count_reg;
    if (r.req_type == REQ_ALLOC) begin
      if (list_nonempty) begin
        g.granted_index   = head;
        g.granted_address = chunk_address(head);
        g.from_free_list  = 1'b1;
        if (link_last[head]) begin
          list_nonempty = 1'b0;
          head          = '0;
        end else begin
          head = link_next[head];
        end
      end else if (bump < lim) begin
        g.granted_index   = bump[IDX_W-1:0];
        g.granted_address = chunk_address(bump[IDX_W-1:0]);
        bump              = bump + 1'b1;
      end else begin
        g.status = STATUS_OOM;
      end
    end else if ({1'b0, r.chunk_index} < lim) begin
      link_next[r.chunk_index] = head;
      link_last[r.chunk_index] = !list_nonempty;
      head                     = r.chunk_index;
      list_nonempty            = 1'b1;
    end else begin
      g.status = STATUS_RANGE;
    end
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      due_grants.delete();
      base_reg      = POOL_BASE_RST;
      bytes_reg     = CHUNK_BYTES_RST;
      count_reg     = CHUNK_COUNT_RST;
      head          = '0;
      list_nonempty = 1'b0;
      bump          = '0;
      pending_o    <= 0;
    end else begin
      // results first so a same-edge request never matches its own grant
      if (out_valid_i && out_ready_i) begin
        if (due_grants.size() == 0) begin
          report($sformatf("result with no request outstanding: %p", out_rsp_i));
        end else begin
          want = due_grants.pop_front();
          if (out_rsp_i.status !== want.status)
            report($sformatf("status: want %0d got %0d", want.status, out_rsp_i.status));
          if (out_rsp_i.granted_index !== want.granted_index)
            report($sformatf("granted_index: want %0d got %0d",
                             want.granted_index, out_rsp_i.granted_index));
          if (out_rsp_i.granted_address !== want.granted_address)
            report($sformatf("granted_address: want %h got %h",
                             want.granted_address, out_rsp_i.granted_address));
          if (out_rsp_i.from_free_list !== want.from_free_list)
            report($sformatf("from_free_list: want %0d got %0d",
                             want.from_free_list, out_rsp_i.from_free_list));
        end
      end
      if (in_valid_i && in_ready_i) due_grants.push_back(pool_serve(in_req_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_POOL_BASE:   base_reg  = cfg_wdata_i;
          CFG_CHUNK_BYTES: bytes_reg = cfg_wdata_i[BYTES_W-1:0];
          CFG_CHUNK_COUNT: count_reg = cfg_wdata_i[CNT_W-1:0];
          default: ;
        endcase
      end
      pending_o <= due_grants.size();
    end
  end

endmodule

// ===== bench/fixed_chunk_pool_allocator_tb.sv =====
// testbench top for the chunk pool allocator: stimulus, config phases and verdict
`timescale 1ns / 100ps

module fixed_chunk_pool_allocator_tb;
  import fcpa_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  req_t                 in_req    = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  rsp_t                 out_rsp;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [ADDR_W-1:0]    cfg_wdata = '0;
  int                   pending;
  int                   fail_count;

  int send_idle_pct = 10;
  int recv_idle_pct = 87;
  int live_count    = MAX_CHUNKS;

  fixed_chunk_pool_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  fcpa_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_rsp_i    (out_rsp),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  task automatic send_req(logic kind, logic [IDX_W-1:0] idx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= '{req_type: kind, chunk_index: idx};
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // upper write bits carry junk to check register masking
  task automatic set_config(logic [ADDR_W-1:0] base, logic [BYTES_W-1:0] bytes,
                            logic [CNT_W-1:0] count);
    logic [ADDR_W-1:0] junk;
    junk = ADDR_W'({$urandom, $urandom});
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_POOL_BASE;
    cfg_wdata <= base;
    @(posedge clk_i);
    cfg_idx   <= CFG_CHUNK_BYTES;
    cfg_wdata <= {junk[ADDR_W-1:BYTES_W], bytes};
    @(posedge clk_i);
    cfg_idx   <= CFG_CHUNK_COUNT;
    cfg_wdata <= {junk[ADDR_W-1:CNT_W], count};
    @(posedge clk_i);
    cfg_idx   <= CFG_SPARE;
    cfg_wdata <= junk;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    live_count = (count > MAX_CHUNKS) ? MAX_CHUNKS : count;
  endtask

  task automatic random_requests(int n, int alloc_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < alloc_pct)
        send_req(REQ_ALLOC, IDX_W'($urandom));
      else if ($urandom_range(0, 99) < 85 && live_count > 0)
        send_req(REQ_RELEASE, IDX_W'($urandom_range(0, live_count - 1)));
      else
        send_req(REQ_RELEASE, IDX_W'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: bump grants, recycling, double release, unused index field
    send_req(REQ_ALLOC, 10'h3FF);
    send_req(REQ_ALLOC, 10'h000);
    send_req(REQ_RELEASE, 10'h3FF);
    send_req(REQ_ALLOC, 10'h155);
    send_req(REQ_RELEASE, 10'd0);
    send_req(REQ_RELEASE, 10'd1);
    send_req(REQ_ALLOC, 10'h2AA);
    send_req(REQ_ALLOC, 10'h000);
    send_req(REQ_ALLOC, 10'h3FF);
    send_req(REQ_RELEASE, 10'h3FF);
    send_req(REQ_RELEASE, 10'h3FF);
    send_req(REQ_ALLOC, 10'h000);
    send_req(REQ_ALLOC, 10'h000);
    send_req(REQ_ALLOC, 10'h000);
    send_req(REQ_RELEASE, 10'd5);
    drain();

    // shrunk pool, address wrap, out of range release
    set_config('1, 21'd1048576, 11'd3);
    send_req(REQ_RELEASE, 10'd2);
    send_req(REQ_RELEASE, 10'd3);
    send_req(REQ_RELEASE, 10'h3FF);
    send_req(REQ_ALLOC, 10'h000);
    send_req(REQ_ALLOC, 10'h000);
    send_req(REQ_ALLOC, 10'h000);
    drain();

    // zero chunk count, zero chunk size
    set_config(ADDR_W'({$urandom, $urandom}), 21'd0, 11'd0);
    send_req(REQ_ALLOC, 10'h000);
    send_req(REQ_RELEASE, 10'd0);
    send_req(REQ_ALLOC, 10'h3FF);
    drain();

    set_config(ADDR_W'({$urandom, $urandom}), BYTES_W'($urandom), 11'd16);
    random_requests(150, 60);
    drain();

    send_idle_pct = 87;
    recv_idle_pct = 10;
    set_config(ADDR_W'({$urandom, $urandom}), 21'd1, 11'h7FF);
    random_requests(75, 55);
    drain();
    random_requests(75, 55);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config('1, 21'h1FFFFF, 11'd1);
    random_requests(75, 45);
    drain();
    set_config('0, BYTES_W'($urandom), 11'd40);
    random_requests(75, 50);
    drain();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
